// ===== rtl/core/bhq_pkg.sv =====
// shared types and codes for the binary min-heap queue
`timescale 1ns / 1ps

package bhq_pkg;

    localparam logic       CMD_INSERT = 1'b0;
    localparam logic       CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic               command;
        logic signed [31:0] value;
    } t_cmd_in;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [8:0]         entry_count;
        logic               is_empty;
        logic [1:0]         status;
    } t_res_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_UP_CHK,
        S_DN_ROOT,
        S_DN_LAST,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_CMP,
        S_WR,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/bhq_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module bhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bhq_cmp.sv =====
// shared signed less-than compare unit
`timescale 1ns / 1ps

module bhq_cmp #(
    parameter int WIDTH = 32
) (
    input  logic signed [WIDTH-1:0] i_a,
    input  logic signed [WIDTH-1:0] i_b,
    output logic                    o_lt
);

    assign o_lt = (i_a < i_b);

endmodule

// ===== rtl/core/bhq_seq.sv =====
// heap sequencer: sift-up and sift-down over the heap ram with one comparator
`timescale 1ns / 1ps

module bhq_seq
    import bhq_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_cmd_in  i_cmd,
    output logic     o_done,
    input  logic     i_take,
    output t_res_out o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    t_state                        r_state, n_state;
    logic                          r_cmd, n_cmd;
    logic signed [ELEM_WIDTH-1:0]  r_v, n_v;
    logic signed [ELEM_WIDTH-1:0]  r_left, n_left;
    logic signed [ELEM_WIDTH-1:0]  r_child, n_child;
    logic signed [ELEM_WIDTH-1:0]  r_removed, n_removed;
    logic [CW-1:0]                 r_k, n_k;
    logic [CW-1:0]                 r_c, n_c;
    logic [CW-1:0]                 r_count, n_count;
    logic [1:0]                    r_status, n_status;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;
    logic [ELEM_WIDTH-1:0]         ram_wdata;
    logic [ELEM_WIDTH-1:0]         ram_rdata;

    logic signed [ELEM_WIDTH-1:0]  cmp_a, cmp_b;
    logic                          cmp_lt;

    logic [CW:0]                   w_left, w_right, w_cleft, w_count;
    logic [CW-1:0]                 w_ins;
    logic [31:0]                   w_count32;

    // slot numbers start at one, ram addresses at zero
    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] slot);
        logic [CW-1:0] t;
        t = slot - 1'b1;
        return AW'(t);
    endfunction

    bhq_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bhq_cmp #(
        .WIDTH (ELEM_WIDTH)
    ) u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt)
    );

    assign w_left  = {r_k, 1'b0};
    assign w_right = w_left + 1'b1;
    assign w_cleft = {r_c, 1'b0};
    assign w_count = {1'b0, r_count};
    assign w_ins   = r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_v       <= n_v;
        r_left    <= n_left;
        r_child   <= n_child;
        r_removed <= n_removed;
        r_k       <= n_k;
        r_c       <= n_c;
        r_status  <= n_status;
    end

    // operand select for the shared compare unit
    always_comb begin
        cmp_a = r_v;
        cmp_b = r_child;
        case (r_state)
            S_UP_CHK: begin
                cmp_b = ram_rdata;
            end
            S_DN_RIGHT: begin
                cmp_a = r_left;
                cmp_b = ram_rdata;
            end
            default: begin
                cmp_a = r_v;
                cmp_b = r_child;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_v       = r_v;
        n_left    = r_left;
        n_child   = r_child;
        n_removed = r_removed;
        n_k       = r_k;
        n_c       = r_c;
        n_count   = r_count;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = f_addr(r_k);
        ram_wdata = r_v;
        ram_raddr = '0;
        o_done    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd.command;
                    n_v     = ELEM_WIDTH'(i_cmd.value);
                    n_state = S_START;
                end
            end
            S_START: begin
                n_removed = '0;
                n_status  = ST_OK;
                if (r_cmd == CMD_INSERT) begin
                    if (r_count == CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_count = w_ins;
                        n_k     = w_ins;
                        if (r_count == '0) begin
                            n_state = S_WR;
                        end else begin
                            ram_raddr = f_addr(w_ins >> 1);
                            n_state   = S_UP_CHK;
                        end
                    end
                end else begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        ram_raddr = f_addr(CW'(1));
                        n_state   = S_DN_ROOT;
                    end
                end
            end
            S_UP_CHK: begin
                // parent value is on the ram output
                if (cmp_lt) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_k       = r_k >> 1;
                    if ((r_k >> 1) == CW'(1)) begin
                        n_state = S_WR;
                    end else begin
                        ram_raddr = f_addr(r_k >> 2);
                    end
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DN_ROOT: begin
                n_removed = ram_rdata;
                ram_raddr = f_addr(r_count);
                n_count   = r_count - 1'b1;
                n_state   = S_DN_LAST;
            end
            S_DN_LAST: begin
                n_v = ram_rdata;
                n_k = CW'(1);
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else if (r_count == CW'(1)) begin
                    n_state = S_WR;
                end else begin
                    ram_raddr = f_addr(CW'(2));
                    n_state   = S_DN_LEFT;
                end
            end
            S_DN_LEFT: begin
                n_left = ram_rdata;
                if (w_right <= w_count) begin
                    ram_raddr = f_addr(CW'(w_right));
                    n_state   = S_DN_RIGHT;
                end else begin
                    n_child = ram_rdata;
                    n_c     = CW'(w_left);
                    n_state = S_DN_CMP;
                end
            end
            S_DN_RIGHT: begin
                // left wins only when strictly smaller
                if (cmp_lt) begin
                    n_child = r_left;
                    n_c     = CW'(w_left);
                end else begin
                    n_child = ram_rdata;
                    n_c     = CW'(w_right);
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    n_state = S_DONE;
                end else begin
                    ram_wdata = r_child;
                    n_k       = r_c;
                    if (w_cleft <= w_count) begin
                        ram_raddr = f_addr(CW'(w_cleft));
                        n_state   = S_DN_LEFT;
                    end else begin
                        n_state = S_WR;
                    end
                end
            end
            S_WR: begin
                ram_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready   = (r_state == S_IDLE);
    assign w_count32 = 32'(r_count);

    assign o_res.removed_value = 32'(r_removed);
    assign o_res.entry_count   = w_count32[8:0];
    assign o_res.is_empty      = (r_count == '0);
    assign o_res.status        = r_status;

endmodule

// ===== rtl/core/binary_min_heap_queue_core.sv =====
// top level of the binary min-heap priority queue
`timescale 1ns / 1ps

// binary min-heap priority queue of signed words, root at slot 1
// command channel: i_in_valid / o_in_ready carry a command (insert value or
//   remove smallest); one command is worked on at a time
// result channel: o_out_valid / i_out_ready carry exactly one result per
//   command: removed value, count after the command, empty flag and status
// insert: the new entry climbs a level per parent read and compare; the next
//   command is taken once the result has moved on to the output register
// remove: the root is read, then the last entry, which sinks a level per
//   left child read, right child read when present and compare, then is
//   written where it stops
// this sequencing is set by the single read port of the heap ram and the one
//   comparator that serves both the child pick and the parent test
// insert when full and remove when empty are reported in status and leave
//   the heap untouched
// reset (synchronous, active low) empties the queue and drops any result;
//   heap ram contents are not cleared, a slot is always written before read
// a finished result sits in the output register; the next command can be
//   taken meanwhile, and its result waits in the sequencer while the
//   receiver stalls

module binary_min_heap_queue_core
    import bhq_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_cmd_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_res_out o_out_data
);

    logic     seq_done;
    logic     seq_take;
    t_res_out seq_res;

    logic     r_out_valid;
    t_res_out r_out_data;

    bhq_seq #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_cmd   (i_in_data),
        .o_done  (seq_done),
        .i_take  (seq_take),
        .o_res   (seq_res)
    );

    // output register is free when empty or being drained this cycle
    assign seq_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done && seq_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded on transfer from the sequencer
    always_ff @(posedge i_clk) begin
        if (seq_done && seq_take) begin
            r_out_data <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
